/* sv/lru_pkg.sv */
package lru_pkg;

    // Built frame count and page number width.
    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;

    // Derived widths.
    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);

    // Port widths fixed by the interface.
    localparam int IN_PAGE_W  = 16;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_PAGE_W = 16;
    localparam int FAULT_W    = 32;
    localparam int CFG_W      = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Victim search tree: frames are reduced in groups, then across groups.
    localparam int GROUP  = 4;
    localparam int GROUPS = (FRAMES + GROUP - 1) / GROUP;

    // Update broadcast to every frame cell.
    typedef struct packed {
        logic                 fire;
        logic                 hit;
        logic [RANK_W-1:0]    hit_rank;
        logic [PAGE_BITS-1:0] page;
    } lru_upd_t;

    // Contents of one frame cell as seen by the control logic.
    typedef struct packed {
        logic                 valid;
        logic [RANK_W-1:0]    rank;
        logic [PAGE_BITS-1:0] page;
        logic                 sel_hit;
        logic                 sel_empty;
    } lru_cell_st_t;

endpackage

/* sv/lru_page_replacement_top.sv */
// LRU page replacement unit. Each transaction on the s_ channel is one page
// reference; each transaction on the m_ channel gives whether it hit, the frame
// that now holds the page, any evicted page and the saturating fault total. The
// frames form a row of cells, each holding its page, occupancy and recency rank.
// A reference passes through a search state, in which every cell compares the
// page and the oldest frame is found through a registered tree, and an update
// state, in which the result is registered and the row is re-ranked. A new
// reference is accepted in the update state, while the last one is finished;
// the update state waits while the result register is held by m_ready.
// frames_in_use is written through the cfg_ port; the user must write it only
// while the unit is idle, which the unit does not enforce. Zero behaves as one
// and values above the built frame count as the full count.
module lru_page_replacement_top
    import lru_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_PAGE_W-1:0]  s_page,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [OUT_IDX_W-1:0]  m_frame_index,
    output logic                  m_evicted_valid,
    output logic [OUT_PAGE_W-1:0] m_evicted_page,
    output logic [FAULT_W-1:0]    m_fault_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SRCH = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]            st_reg;
    logic [1:0]            st_next;
    logic [CFG_W-1:0]      cfg_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FAULT_W-1:0]    fault_reg;
    logic [FAULT_W-1:0]    fault_next;

    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [OUT_IDX_W-1:0]  m_idx_reg;
    logic                  m_ev_valid_reg;
    logic [OUT_PAGE_W-1:0] m_ev_page_reg;
    logic [FAULT_W-1:0]    m_fault_reg;

    logic                  out_free;
    logic                  in_acc;
    logic                  capture;
    logic                  fire;

    logic [FRAMES-1:0]     managed;
    logic                  match_chain [FRAMES+1];
    logic                  empty_chain [FRAMES+1];
    lru_cell_st_t          cell_st [FRAMES];
    logic [RANK_W-1:0]     ranks [FRAMES];
    logic [FRAMES-1:0]     chosen;
    logic [IDX_W-1:0]      victim_idx;
    lru_upd_t              upd;

    logic                  any_hit;
    logic                  any_empty;
    logic [RANK_W-1:0]     hit_rank;
    logic [IDX_W-1:0]      f_idx;
    logic [PAGE_BITS-1:0]  ev_page;

    // Configuration register; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid) begin
            cfg_reg <= cfg_data;
        end
    end

    // Handshake and sequencing.
    assign out_free = ~m_valid_reg | m_ready;
    assign s_ready  = (st_reg == ST_IDLE) || ((st_reg == ST_UPD) && out_free);
    assign in_acc   = s_valid & s_ready;
    assign capture  = (st_reg == ST_SRCH);
    assign fire     = (st_reg == ST_UPD) && out_free;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    st_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                st_next = ST_UPD;
            end
            ST_UPD: begin
                if (fire) begin
                    st_next = in_acc ? ST_SRCH : ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            page_reg <= PAGE_BITS'(s_page);
        end
    end

    // Row of frame cells.
    assign match_chain[0] = 1'b0;
    assign empty_chain[0] = 1'b0;

    for (genvar j = 0; j < FRAMES; j++) begin : g_cell
        assign managed[j] = (j == 0) || (int'(cfg_reg) > j);
        assign ranks[j]   = cell_st[j].rank;

        lru_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .managed     (managed[j]),
            .search_page (page_reg),
            .capture     (capture),
            .match_in    (match_chain[j]),
            .empty_in    (empty_chain[j]),
            .match_out   (match_chain[j+1]),
            .empty_out   (empty_chain[j+1]),
            .upd         (upd),
            .chosen      (chosen[j]),
            .status      (cell_st[j])
        );
    end

    // Oldest managed frame.
    lru_victim u_victim (
        .aclk       (aclk),
        .capture    (capture),
        .eligible   (managed),
        .rank       (ranks),
        .victim_idx (victim_idx)
    );

    // Decision in the update cycle: hit frame, else first empty frame, else victim.
    always_comb begin
        any_hit   = 1'b0;
        any_empty = 1'b0;
        hit_rank  = '0;
        for (int j = 0; j < FRAMES; j++) begin
            any_hit   = any_hit | cell_st[j].sel_hit;
            any_empty = any_empty | cell_st[j].sel_empty;
            hit_rank  = hit_rank | (cell_st[j].sel_hit ? cell_st[j].rank : '0);
        end
    end

    always_comb begin
        chosen  = '0;
        f_idx   = '0;
        ev_page = '0;
        for (int j = 0; j < FRAMES; j++) begin
            if (any_hit) begin
                chosen[j] = cell_st[j].sel_hit;
            end else if (any_empty) begin
                chosen[j] = cell_st[j].sel_empty;
            end else begin
                chosen[j] = (victim_idx == IDX_W'(j));
            end
            f_idx   = f_idx | (chosen[j] ? IDX_W'(j) : '0);
            ev_page = ev_page | (chosen[j] ? cell_st[j].page : '0);
        end
    end

    assign upd.fire     = fire;
    assign upd.hit      = any_hit;
    assign upd.hit_rank = hit_rank;
    assign upd.page     = page_reg;

    // Saturating fault total.
    always_comb begin
        fault_next = fault_reg;
        if (!any_hit && (fault_reg != {FAULT_W{1'b1}})) begin
            fault_next = fault_reg + FAULT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_reg <= '0;
        end else if (fire) begin
            fault_reg <= fault_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_hit_reg      <= any_hit;
            m_idx_reg      <= OUT_IDX_W'(f_idx);
            m_ev_valid_reg <= ~any_hit & ~any_empty;
            m_ev_page_reg  <= (~any_hit & ~any_empty) ? OUT_PAGE_W'(ev_page) : '0;
            m_fault_reg    <= fault_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_frame_index   = m_idx_reg;
    assign m_evicted_valid = m_ev_valid_reg;
    assign m_evicted_page  = m_ev_page_reg;
    assign m_fault_count   = m_fault_reg;

endmodule

/* sv/lru_cell.sv */
module lru_cell
    import lru_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 managed,
    input  logic [PAGE_BITS-1:0] search_page,
    input  logic                 capture,
    input  logic                 match_in,
    input  logic                 empty_in,
    output logic                 match_out,
    output logic                 empty_out,
    input  lru_upd_t             upd,
    input  logic                 chosen,
    output lru_cell_st_t         status
);

    logic                 valid_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 sel_hit_reg;
    logic                 sel_empty_reg;
    logic                 my_match;
    logic                 my_empty;
    logic                 ages;

    // Local compare; the first match and first empty frame ripple along the row.
    assign my_match  = managed & valid_reg & (page_reg == search_page);
    assign my_empty  = managed & ~valid_reg;
    assign match_out = match_in | my_match;
    assign empty_out = empty_in | my_empty;

    // A hit ages only the younger frames; a fault ages all others up to the ceiling.
    assign ages = upd.hit ? (rank_reg < upd.hit_rank) : (rank_reg != RANK_MAX);

    // Selection flags are captured in the search cycle.
    always_ff @(posedge aclk) begin
        if (capture) begin
            sel_hit_reg   <= my_match & ~match_in;
            sel_empty_reg <= my_empty & ~empty_in;
        end
    end

    // The page is loaded when this frame takes a faulting reference.
    always_ff @(posedge aclk) begin
        if (upd.fire && chosen && !upd.hit) begin
            page_reg <= upd.page;
        end
    end

    // Occupancy and recency rank.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else if (upd.fire && managed) begin
            if (chosen) begin
                valid_reg <= 1'b1;
                rank_reg  <= '0;
            end else if (valid_reg && ages) begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

    assign status.valid     = valid_reg;
    assign status.rank      = rank_reg;
    assign status.page      = page_reg;
    assign status.sel_hit   = sel_hit_reg;
    assign status.sel_empty = sel_empty_reg;

endmodule

/* sv/lru_victim.sv */
module lru_victim
    import lru_pkg::*;
(
    input  logic              aclk,
    input  logic              capture,
    input  logic [FRAMES-1:0] eligible,
    input  logic [RANK_W-1:0] rank [FRAMES],
    output logic [IDX_W-1:0]  victim_idx
);

    logic [RANK_W-1:0] grp_best_reg  [GROUPS];
    logic [IDX_W-1:0]  grp_idx_reg   [GROUPS];
    logic              grp_any_reg   [GROUPS];
    logic [RANK_W-1:0] grp_best_next [GROUPS];
    logic [IDX_W-1:0]  grp_idx_next  [GROUPS];
    logic              grp_any_next  [GROUPS];

    // First level: oldest frame in each group, lowest index on a tie.
    always_comb begin
        int j;
        for (int g = 0; g < GROUPS; g++) begin
            grp_best_next[g] = '0;
            grp_idx_next[g]  = '0;
            grp_any_next[g]  = 1'b0;
            for (int k = 0; k < GROUP; k++) begin
                j = g * GROUP + k;
                if (j < FRAMES) begin
                    if (eligible[IDX_W'(j)] &&
                        (!grp_any_next[g] || rank[IDX_W'(j)] > grp_best_next[g])) begin
                        grp_best_next[g] = rank[IDX_W'(j)];
                        grp_idx_next[g]  = IDX_W'(j);
                        grp_any_next[g]  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            grp_best_reg <= grp_best_next;
            grp_idx_reg  <= grp_idx_next;
            grp_any_reg  <= grp_any_next;
        end
    end

    // Second level: oldest across the groups, earlier group wins a tie.
    always_comb begin
        logic              found;
        logic [RANK_W-1:0] best;
        found      = 1'b0;
        best       = '0;
        victim_idx = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (grp_any_reg[g] && (!found || grp_best_reg[g] > best)) begin
                found      = 1'b1;
                best       = grp_best_reg[g];
                victim_idx = grp_idx_reg[g];
            end
        end
    end

endmodule

/* sv/lru_checker.sv */
module lru_checker
    import lru_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_hit,
    input logic [OUT_IDX_W-1:0]  m_frame_index,
    input logic                  m_evicted_valid,
    input logic [OUT_PAGE_W-1:0] m_evicted_page
);

    // A stalled result transaction holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_frame_index) &&
            $stable(m_evicted_valid) && $stable(m_evicted_page))
        else $error("result changed while stalled");

    // A hit never evicts a page.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_evicted_valid)
        else $error("eviction reported on a hit");

    // The evicted page reads as zero when nothing was evicted.
    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> m_evicted_page == '0)
        else $error("evicted page not zero without eviction");

endmodule

bind lru_page_replacement_top lru_checker u_lru_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_hit           (m_hit),
    .m_frame_index   (m_frame_index),
    .m_evicted_valid (m_evicted_valid),
    .m_evicted_page  (m_evicted_page)
);
